### rtl/core/sdiv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_pkg
// shared types for the saturating signed divider: sequencer states and the
// control bundle from the sequencer to the datapath
// ----------------------------------------------------------------------------
package sdiv_pkg;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIX  = 3'b100
  } sdiv_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } sdiv_ctrl_t;

endpackage

### rtl/core/sdiv_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_req_if
// request channel of the divider: dividend and divisor with valid/ready
// ----------------------------------------------------------------------------
interface sdiv_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [DATA_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

### rtl/core/sdiv_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_rsp_if
// response channel of the divider: quotient with valid/ready
// ----------------------------------------------------------------------------
interface sdiv_rsp_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

### rtl/core/sdiv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_ctrl
// sequencer: takes a request, runs one shift-subtract step per cycle for
// every quotient bit, then a sign/saturation state that loads the output
// ----------------------------------------------------------------------------
module sdiv_ctrl
  import sdiv_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_free,
  output logic       in_ready,
  output sdiv_ctrl_t ctrl
);

  localparam int CW = $clog2(DATA_WIDTH);

  sdiv_state_t   state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = (state == ST_IDLE);
    ctrl.load  = 1'b0;
    ctrl.step  = 1'b0;
    ctrl.fix   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          cnt_next   = CW'(DATA_WIDTH - 1);
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_FIX;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      ST_FIX: begin
        if (out_free) begin
          ctrl.fix   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### rtl/core/sdiv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_datapath
// magnitude registers and the shared compare-subtract unit of the restoring
// divider; the dividend register shifts out dividend bits and shifts in
// quotient bits, then the sign and saturation are applied to the result
// ----------------------------------------------------------------------------
module sdiv_datapath
  import sdiv_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  sdiv_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] numerator,
  input  logic [DATA_WIDTH-1:0] denominator,
  output logic [DATA_WIDTH-1:0] result
);

  localparam logic [DATA_WIDTH-1:0] PosMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] One    = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  logic [DATA_WIDTH-1:0] dvd;
  logic [DATA_WIDTH-1:0] dvs;
  logic [DATA_WIDTH-1:0] rem;
  logic                  nneg;
  logic                  dneg;

  logic [DATA_WIDTH-1:0] rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] neg_q;

  // shared compare-subtract unit
  assign rem_sh = {rem[DATA_WIDTH-2:0], dvd[DATA_WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvs};
  assign ge     = ~diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      nneg <= numerator[DATA_WIDTH-1];
      dneg <= denominator[DATA_WIDTH-1];
      dvd  <= numerator[DATA_WIDTH-1] ? (~numerator) + One : numerator;
      dvs  <= denominator[DATA_WIDTH-1] ? (~denominator) + One : denominator;
      rem  <= '0;
    end else if (ctrl.step) begin
      rem <= ge ? diff[DATA_WIDTH-1:0] : rem_sh;
      dvd <= {dvd[DATA_WIDTH-2:0], ge};
    end
  end

  // sign and saturation
  assign neg_q = (~dvd) + One;

  always_comb begin
    if (dvs == '0) begin
      result = PosMax;
    end else if (nneg != dneg) begin
      result = neg_q;
    end else if (dvd[DATA_WIDTH-1]) begin
      result = PosMax;
    end else begin
      result = dvd;
    end
  end

endmodule

### rtl/core/signed_int_divider_saturating_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_divider_saturating_core
// signed divider, quotient truncated toward zero, saturating on a zero
// divisor and on most-negative over minus one
//
//   channel | dir | payload                  | handshake
//   --------+-----+--------------------------+------------
//   req     | in  | numerator, denominator   | valid/ready
//   rsp     | out | quotient                 | valid/ready
//
// the load happens at the accepting edge, then one quotient bit per cycle is
// worked out in the shared compare-subtract unit, then a sign/saturation
// state loads the quotient into the output register; the next request is
// taken only after that load, when the sequencer is back in idle
// req.ready is high only while the sequencer is idle
// the quotient sits in an output register; a stalled rsp holds the sequencer
// in its last cycle until the register frees
// rst is synchronous and clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module signed_int_divider_saturating_core
  import sdiv_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  sdiv_req_if.sink   req,
  sdiv_rsp_if.source rsp
);

  sdiv_ctrl_t            ctrl;
  logic                  in_ready;
  logic                  out_free;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_data;
  logic [DATA_WIDTH-1:0] result;

  assign out_free = ~out_valid | rsp.ready;

  sdiv_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .out_free(out_free),
    .in_ready(in_ready),
    .ctrl    (ctrl)
  );

  sdiv_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .ctrl       (ctrl),
    .numerator  (req.numerator),
    .denominator(req.denominator),
    .result     (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fix) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fix) begin
      out_data <= result;
    end
  end

  assign req.ready    = in_ready;
  assign rsp.valid    = out_valid;
  assign rsp.quotient = out_data;

endmodule

### rtl/core/sdiv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_checker
// port-level checks of the divider, attached to the top level by bind
// ----------------------------------------------------------------------------
module sdiv_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [DATA_WIDTH-1:0] rsp_quotient
);

  // stalled response stays valid
  a_rsp_hold : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // stalled response keeps its quotient
  a_rsp_stable : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_quotient))
    else $error("quotient changed while stalled");

  // busy after taking a request
  a_busy : assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while divider busy");

  // no quotient appears right after a request
  a_latency : assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("quotient too early");

endmodule

bind signed_int_divider_saturating_core sdiv_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sdiv_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_quotient(rsp.quotient)
);

### verif/tb_signed_int_divider_saturating_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_divider_saturating_core
// self-checking bench for the saturating signed divider: directed corner
// divisions, then mixed random operands under random idling on both
// channels, a gap-free stretch and a long response stall; each accepted
// request gets a predicted quotient that is compared in order with the
// returned one
// ----------------------------------------------------------------------------
module tb_signed_int_divider_saturating_core;

  localparam int DW = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] POS_MAX  = {1'b0, {(DW-1){1'b1}}};

  typedef struct {
    logic signed [DW-1:0] numerator;
    logic signed [DW-1:0] denominator;
    logic signed [DW-1:0] quotient;
  } division_t;

  logic clk;
  logic rst;

  sdiv_req_if #(.DATA_WIDTH(DW)) req_bus ();
  sdiv_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

  signed_int_divider_saturating_core #(
    .DATA_WIDTH(DW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  division_t   pending_divisions[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap_pct = 22;
  int unsigned recv_gap_pct = 22;
  bit          hold_off_request = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic signed [DW-1:0] predict_quotient(
    input logic signed [DW-1:0] n,
    input logic signed [DW-1:0] d
  );
    logic [DW-1:0] n_mag;
    logic [DW-1:0] d_mag;
    logic [DW-1:0] q;
    n_mag = n[DW-1] ? (~n + 1'b1) : n;
    d_mag = d[DW-1] ? (~d + 1'b1) : d;
    if (d_mag == '0) return POS_MAX;
    q = n_mag / d_mag;
    if (n[DW-1] != d[DW-1]) return ~q + 1'b1;
    if (q > POS_MAX) return POS_MAX;
    return q;
  endfunction

  function automatic logic signed [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(5))
      0, 1: v = $urandom;
      2: v = $urandom_range(40) - 20;
      3: begin
        v = $urandom >> $urandom_range(DW-1);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      4: begin
        case ($urandom_range(4))
          0: v = MOST_NEG;
          1: v = POS_MAX;
          2: v = '0;
          3: v = 1;
          default: v = '1;
        endcase
      end
      default: begin
        v = 1 << $urandom_range(DW-1);
        if ($urandom_range(1)) v = v - 1'b1;
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  // request side: valid stays high from one request to the next unless a gap is taken
  task automatic send_division(input logic signed [DW-1:0] n, input logic signed [DW-1:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk);
    req_bus.valid       <= 1'b1;
    req_bus.numerator   <= n;
    req_bus.denominator <= d;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          rsp_bus.ready <= 1'b0;
          @(negedge clk);
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    division_t exp_div;
    division_t new_div;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_divisions.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected quotient %0d with no request pending", rsp_bus.quotient);
          error_count++;
        end else begin
          exp_div = pending_divisions.pop_front();
          if (rsp_bus.quotient !== exp_div.quotient) begin
            if (error_count < MAX_REPORTS)
              $display("mismatch: %0d / %0d expected %0d got %0d", exp_div.numerator,
                       exp_div.denominator, exp_div.quotient, rsp_bus.quotient);
            error_count++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        new_div.numerator   = req_bus.numerator;
        new_div.denominator = req_bus.denominator;
        new_div.quotient    = predict_quotient(req_bus.numerator, req_bus.denominator);
        pending_divisions.push_back(new_div);
      end
    end
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb_signed_int_divider_saturating_core NOT OK");
    $finish;
  end

  task automatic test_directed_corners();
    send_division(0, 1);
    send_division(0, -1);
    send_division(0, MOST_NEG);
    send_division(POS_MAX, 1);
    send_division(MOST_NEG, 1);
    send_division(MOST_NEG, -1);
    send_division(POS_MAX, -1);
    send_division(5, 0);
    send_division(-5, 0);
    send_division(0, 0);
    send_division(MOST_NEG, 0);
    send_division(POS_MAX, 0);
    send_division(MOST_NEG, MOST_NEG);
    send_division(POS_MAX, MOST_NEG);
    send_division(-1, MOST_NEG);
    send_division(POS_MAX, POS_MAX);
    send_division(MOST_NEG, POS_MAX);
    send_division(MOST_NEG, 2);
    send_division(7, 2);
    send_division(-7, 2);
    send_division(7, -2);
    send_division(-7, -2);
    send_division(1, POS_MAX);
    send_division(-1, -1);
  endtask

  task automatic test_random_division(input int unsigned count);
    logic signed [DW-1:0] n;
    logic signed [DW-1:0] d;
    repeat (count) begin
      n = pick_operand();
      case ($urandom_range(9))
        0: d = n;
        1: d = ~n + 1'b1;
        2: d = n >>> $urandom_range(DW-1);
        default: d = pick_operand();
      endcase
      send_division(n, d);
    end
  endtask

  task automatic test_steady_stream();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_division(200);
    send_gap_pct = 22;
    recv_gap_pct = 22;
  endtask

  task automatic test_output_stall();
    send_gap_pct = 0;
    hold_off_request = 1'b1;
    test_random_division(80);
    send_gap_pct = 22;
  endtask

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.numerator = '0;
    req_bus.denominator = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_division(700);
    test_steady_stream();
    test_output_stall();
    test_random_division(700);

    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_divisions.size() != 0) @(negedge clk);
    repeat (DW + 8) @(posedge clk);

    if (error_count == 0 && pending_divisions.size() == 0) begin
      $display("tb_signed_int_divider_saturating_core OK");
    end else begin
      $display("tb_signed_int_divider_saturating_core NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sdiv_pkg.sv
rtl/core/sdiv_req_if.sv
rtl/core/sdiv_rsp_if.sv
rtl/core/sdiv_ctrl.sv
rtl/core/sdiv_datapath.sv
rtl/core/signed_int_divider_saturating_core.sv
rtl/core/sdiv_checker.sv
verif/tb_signed_int_divider_saturating_core.sv
